/* sv/mhsba_pkg.sv */
package mhsba_pkg;

	localparam int IDX_W      = 26;
	localparam int WORD_W     = 32;
	localparam int ADDR_W     = 38;
	localparam int POS_W      = 5;
	localparam int BL_W       = 5;
	localparam int LL_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;
	localparam int LATENCY    = 5;

	localparam logic [BL_W-1:0] BL_MIN    = 5'd5;
	localparam logic [BL_W-1:0] BL_RESET  = 5'd5;
	localparam logic [LL_W-1:0] LL_MIN    = 4'd3;
	localparam logic [LL_W-1:0] LL_MAX    = 4'd12;
	localparam logic [LL_W-1:0] LL_RESET  = 4'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCKS_LOG2    = 2'd0,
		REG_BLOCK_LEN_LOG2 = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic err;
		logic dep;
	} ctrl_t;

endpackage

/* sv/mhsba_slide.sv */
module mhsba_slide (
	input  logic                          clk,
	input  logic [mhsba_pkg::IDX_W-1:0]   idx,
	output logic [mhsba_pkg::IDX_W-1:0]   slide_s3
);

	logic [mhsba_pkg::POS_W-1:0] top;
	logic [mhsba_pkg::IDX_W-1:0] idx_s2;
	logic [mhsba_pkg::POS_W-1:0] top_s2;
	logic [mhsba_pkg::IDX_W-1:0] flip;
	logic [mhsba_pkg::IDX_W-1:0] rev;
	logic [mhsba_pkg::IDX_W-1:0] weight;
	logic [mhsba_pkg::IDX_W:0]   sum;

	always_comb begin
		top = '0;
		for (int k = 1; k < mhsba_pkg::IDX_W; k++) begin
			if (idx[k]) begin
				top = mhsba_pkg::POS_W'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s2 <= idx;
		top_s2 <= top;
	end

	always_comb begin
		for (int k = 0; k < mhsba_pkg::IDX_W; k++) begin
			flip[k] = idx_s2[mhsba_pkg::IDX_W-1-k];
		end
		rev    = flip >> (mhsba_pkg::POS_W'(mhsba_pkg::IDX_W) - top_s2);
		weight = mhsba_pkg::IDX_W'(1) << top_s2;
		sum    = {1'b0, rev} + {1'b0, weight};
	end

	always_ff @(posedge clk) begin
		slide_s3 <= (sum < {1'b0, idx_s2}) ? sum[mhsba_pkg::IDX_W-1:0] : rev;
	end

endmodule

/* sv/mhsba_cube.sv */
module mhsba_cube (
	input  logic                          clk,
	input  logic [mhsba_pkg::WORD_W-1:0]  frac,
	input  logic [mhsba_pkg::IDX_W-1:0]   prev,
	output logic [mhsba_pkg::IDX_W-1:0]   dist_s4
);

	logic [2*mhsba_pkg::WORD_W-1:0]               sq;
	logic [2*mhsba_pkg::WORD_W-1:0]               cu;
	logic [mhsba_pkg::IDX_W+mhsba_pkg::WORD_W-1:0] sc;
	logic [mhsba_pkg::WORD_W-1:0]                 v_s2;
	logic [mhsba_pkg::WORD_W-1:0]                 v2_s2;
	logic [mhsba_pkg::IDX_W-1:0]                  prev_s2;
	logic [mhsba_pkg::WORD_W-1:0]                 v3_s3;
	logic [mhsba_pkg::IDX_W-1:0]                  prev_s3;

	assign sq = frac * frac;
	assign cu = v_s2 * v2_s2;
	assign sc = prev_s3 * v3_s3;

	always_ff @(posedge clk) begin
		v_s2    <= frac;
		v2_s2   <= sq[2*mhsba_pkg::WORD_W-1:mhsba_pkg::WORD_W];
		prev_s2 <= prev;
		v3_s3   <= cu[2*mhsba_pkg::WORD_W-1:mhsba_pkg::WORD_W];
		prev_s3 <= prev_s2;
		dist_s4 <= sc[mhsba_pkg::IDX_W+mhsba_pkg::WORD_W-1:mhsba_pkg::WORD_W];
	end

endmodule

/* sv/memory_hard_source_block_address_unit.sv */
// Channel    Direction  Signals                                   Handshake
// item       in         start, busy, block_index, state_word      start & !busy
// result     out        done, source_block, source_word_addr,     done, one cycle
//                       dependent_phase, index_error
// config     in         cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid & cfg_ready
//
// One item per cycle; busy stays low. Each result passes from its start beat through
// the input register, the three registered 32-bit multiplies of the cubed distance
// and the output register. Results come out in input order and cannot be held off.
// arst_n clears the valid bits and loads the register reset values (5 and 3).
// Write configuration only while no result is pending.
module memory_hard_source_block_address_unit #(
	parameter int MAX_BLOCKS_LOG2 = 26
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [mhsba_pkg::IDX_W-1:0]          block_index,
	input  logic [mhsba_pkg::WORD_W-1:0]         state_word,
	output logic                                 done,
	output logic [mhsba_pkg::IDX_W-1:0]          source_block,
	output logic [mhsba_pkg::ADDR_W-1:0]         source_word_addr,
	output logic                                 dependent_phase,
	output logic                                 index_error,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mhsba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mhsba_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [mhsba_pkg::BL_W-1:0] BlMax = mhsba_pkg::BL_W'(MAX_BLOCKS_LOG2);

	logic [mhsba_pkg::BL_W-1:0]   blocks_log2_q;
	logic [mhsba_pkg::LL_W-1:0]   block_len_log2_q;
	logic [mhsba_pkg::BL_W-1:0]   bl_eff;
	logic [mhsba_pkg::LL_W-1:0]   ll_eff;

	mhsba_pkg::ctrl_t             ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [mhsba_pkg::IDX_W-1:0]  idx_s1;
	logic [mhsba_pkg::WORD_W-1:0] v_s1;
	logic [mhsba_pkg::IDX_W-1:0]  prev_s1;
	logic [mhsba_pkg::IDX_W-1:0]  prev_s2, prev_s3, prev_s4;
	logic [mhsba_pkg::IDX_W-1:0]  slide_s3, slide_s4;
	logic [mhsba_pkg::IDX_W-1:0]  dist_s4;
	logic [mhsba_pkg::IDX_W-1:0]  src;
	logic [mhsba_pkg::IDX_W-1:0]  src_s5;
	logic [mhsba_pkg::ADDR_W-1:0] addr_s5;
	logic                         err_c, dep_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_log2_q    <= mhsba_pkg::BL_RESET;
			block_len_log2_q <= mhsba_pkg::LL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mhsba_pkg::REG_BLOCKS_LOG2:    blocks_log2_q    <= cfg_data;
				mhsba_pkg::REG_BLOCK_LEN_LOG2: block_len_log2_q <= cfg_data[mhsba_pkg::LL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		bl_eff = blocks_log2_q;
		if (bl_eff < mhsba_pkg::BL_MIN) bl_eff = mhsba_pkg::BL_MIN;
		if (bl_eff > BlMax) bl_eff = BlMax;
		ll_eff = block_len_log2_q;
		if (ll_eff < mhsba_pkg::LL_MIN) ll_eff = mhsba_pkg::LL_MIN;
		if (ll_eff > mhsba_pkg::LL_MAX) ll_eff = mhsba_pkg::LL_MAX;
	end

	always_ff @(posedge clk) begin
		idx_s1 <= block_index;
		v_s1   <= state_word;
	end

	always_comb begin
		err_c   = (idx_s1 == '0) || ((idx_s1 >> bl_eff) != '0);
		dep_c   = (idx_s1 >> (bl_eff - mhsba_pkg::BL_W'(1))) != '0;
		prev_s1 = idx_s1 - mhsba_pkg::IDX_W'(1);
	end

	mhsba_slide u_slide (
		.clk      (clk),
		.idx      (idx_s1),
		.slide_s3 (slide_s3)
	);

	mhsba_cube u_cube (
		.clk     (clk),
		.frac    (v_s1),
		.prev    (prev_s1),
		.dist_s4 (dist_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else begin
			ctrl_s1 <= '{valid: start && !busy, err: 1'b0, dep: 1'b0};
			ctrl_s2 <= '{valid: ctrl_s1.valid, err: err_c, dep: dep_c && !err_c};
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		prev_s2  <= prev_s1;
		prev_s3  <= prev_s2;
		prev_s4  <= prev_s3;
		slide_s4 <= slide_s3;
	end

	always_comb begin
		if (ctrl_s4.err) begin
			src = '0;
		end else if (ctrl_s4.dep) begin
			src = prev_s4 - dist_s4;
		end else begin
			src = slide_s4;
		end
	end

	always_ff @(posedge clk) begin
		src_s5  <= src;
		addr_s5 <= mhsba_pkg::ADDR_W'(src) << ll_eff;
	end

	assign done             = ctrl_s5.valid;
	assign source_block     = src_s5;
	assign source_word_addr = addr_s5;
	assign dependent_phase  = ctrl_s5.dep;
	assign index_error      = ctrl_s5.err;

endmodule

/* sv/mhsba_checker.sv */
module mhsba_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [mhsba_pkg::IDX_W-1:0]          source_block,
	input logic [mhsba_pkg::ADDR_W-1:0]         source_word_addr,
	input logic                                 dependent_phase,
	input logic                                 index_error
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(mhsba_pkg::LATENCY) done)
		else $error("result beat missing after start");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##(mhsba_pkg::LATENCY) !done)
		else $error("result beat without start");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |->
			(source_block == '0 && source_word_addr == '0 && !dependent_phase))
		else $error("error result not cleared");

	a_addr_align: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (source_word_addr[2:0] == 3'd0))
		else $error("word address below minimum block length");

endmodule

bind memory_hard_source_block_address_unit mhsba_checker u_mhsba_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int BLOCKS_LOG2_CAP = 26;
	localparam logic [mhsba_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [mhsba_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam logic [mhsba_pkg::WORD_W-1:0] WORD_ALL = '1;
	localparam int RANDOM_PHASES = 13;
	localparam int BEATS_PER_PHASE = 150;

	typedef struct packed {
		logic [mhsba_pkg::IDX_W-1:0]  src;
		logic [mhsba_pkg::ADDR_W-1:0] addr;
		logic                         dep;
		logic                         err;
	} source_beat_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             start = 1'b0;
	logic                             busy;
	logic [mhsba_pkg::IDX_W-1:0]      block_index = '0;
	logic [mhsba_pkg::WORD_W-1:0]     state_word = '0;
	logic                             done;
	logic [mhsba_pkg::IDX_W-1:0]      source_block;
	logic [mhsba_pkg::ADDR_W-1:0]     source_word_addr;
	logic                             dependent_phase;
	logic                             index_error;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [mhsba_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [mhsba_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [mhsba_pkg::BL_W-1:0] blocks_log2_sh = mhsba_pkg::BL_RESET;
	logic [mhsba_pkg::LL_W-1:0] len_log2_sh = mhsba_pkg::LL_RESET;
	source_beat_t    pending_sources[$];
	int              error_count = 0;
	bit              gaps_on = 1'b1;

	memory_hard_source_block_address_unit #(
		.MAX_BLOCKS_LOG2(BLOCKS_LOG2_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.block_index(block_index),
		.state_word(state_word),
		.done(done),
		.source_block(source_block),
		.source_word_addr(source_word_addr),
		.dependent_phase(dependent_phase),
		.index_error(index_error),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned eff_blocks_log2();
		int unsigned b;
		b = blocks_log2_sh;
		if (b < mhsba_pkg::BL_MIN) b = mhsba_pkg::BL_MIN;
		if (b > BLOCKS_LOG2_CAP) b = BLOCKS_LOG2_CAP;
		return b;
	endfunction

	function automatic source_beat_t predict_source(logic [mhsba_pkg::IDX_W-1:0] idx,
		logic [mhsba_pkg::WORD_W-1:0] word);
		source_beat_t    res;
		longint unsigned count, i, v, f2, f3, rev, x, w;
		int unsigned     ll, top;
		res = '0;
		count = 64'd1 << eff_blocks_log2();
		i = idx;
		v = word;
		if (i == 0 || i >= count) begin
			res.err = 1'b1;
			return res;
		end
		ll = len_log2_sh;
		if (ll < mhsba_pkg::LL_MIN) ll = mhsba_pkg::LL_MIN;
		if (ll > mhsba_pkg::LL_MAX) ll = mhsba_pkg::LL_MAX;
		if (i < (count >> 1)) begin
			top = 0;
			while (top < 63 && (i >> (top + 1)) != 0) top++;
			w = 64'd1 << top;
			x = i;
			rev = 0;
			repeat (top) begin
				rev = (rev << 1) | (x & 64'd1);
				x = x >> 1;
			end
			if (rev + w < i) rev = rev + w;
		end else begin
			f2 = (v * v) >> mhsba_pkg::WORD_W;
			f3 = (v * f2) >> mhsba_pkg::WORD_W;
			rev = i - 1 - (((i - 1) * f3) >> mhsba_pkg::WORD_W);
			res.dep = 1'b1;
		end
		res.src = rev[mhsba_pkg::IDX_W-1:0];
		res.addr = mhsba_pkg::ADDR_W'(res.src) << ll;
		return res;
	endfunction

	function automatic logic [mhsba_pkg::IDX_W-1:0] random_index();
		longint unsigned count;
		int unsigned     pick;
		count = 64'd1 << eff_blocks_log2();
		pick = $urandom_range(0, 99);
		if (pick < 8) return mhsba_pkg::IDX_W'($urandom);
		if (pick < 10) return '0;
		if (pick < 14 && count < (64'd1 << mhsba_pkg::IDX_W))
			return mhsba_pkg::IDX_W'(count + $urandom_range(0, 1000));
		if (pick < 22) begin
			case ($urandom_range(0, 3))
				0: return mhsba_pkg::IDX_W'(1);
				1: return mhsba_pkg::IDX_W'((count >> 1) - 1);
				2: return mhsba_pkg::IDX_W'(count >> 1);
				default: return mhsba_pkg::IDX_W'(count - 1);
			endcase
		end
		return mhsba_pkg::IDX_W'($urandom_range(1, int'(count - 1)));
	endfunction

	function automatic logic [mhsba_pkg::WORD_W-1:0] random_word();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) return '0;
		if (pick < 10) return WORD_ALL;
		return $urandom;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		error_count++;
		if (error_count <= 50)
			$display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	always @(negedge clk) begin
		source_beat_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_sources.size() == 0) begin
				report_mismatch("unexpected result beat", source_block, '0);
			end else begin
				want = pending_sources.pop_front();
				if (source_block !== want.src)
					report_mismatch("source_block", source_block, want.src);
				if (source_word_addr !== want.addr)
					report_mismatch("source_word_addr", source_word_addr, want.addr);
				if (dependent_phase !== want.dep)
					report_mismatch("dependent_phase", dependent_phase, want.dep);
				if (index_error !== want.err)
					report_mismatch("index_error", index_error, want.err);
			end
		end
	end

	task automatic send_item(logic [mhsba_pkg::IDX_W-1:0] idx,
		logic [mhsba_pkg::WORD_W-1:0] word);
		bit taken;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		block_index <= idx;
		state_word <= word;
		taken = 1'b0;
		do begin
			@(negedge clk);
			if (!busy) begin
				taken = 1'b1;
				pending_sources.push_back(predict_source(idx, word));
			end
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_sources.size() != 0) @(posedge clk);
		repeat (mhsba_pkg::LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [mhsba_pkg::CFG_IDX_W-1:0] idx,
		logic [mhsba_pkg::CFG_DATA_W-1:0] data);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		taken = 1'b0;
		do begin
			@(negedge clk);
			if (cfg_ready) begin
				taken = 1'b1;
				if (idx == mhsba_pkg::REG_BLOCKS_LOG2)
					blocks_log2_sh = data[mhsba_pkg::BL_W-1:0];
				else if (idx == mhsba_pkg::REG_BLOCK_LEN_LOG2)
					len_log2_sh = data[mhsba_pkg::LL_W-1:0];
			end
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_values();
		send_item('0, 32'h1234_5678);
		send_item(mhsba_pkg::IDX_W'(1), WORD_ALL);
		send_item(mhsba_pkg::IDX_W'(2), '0);
		send_item(mhsba_pkg::IDX_W'(15), 32'h5A5A_5A5A);
		send_item(mhsba_pkg::IDX_W'(16), '0);
		send_item(mhsba_pkg::IDX_W'(16), WORD_ALL);
		send_item(mhsba_pkg::IDX_W'(31), WORD_ALL);
		send_item(mhsba_pkg::IDX_W'(32), '0);
		send_item('1, WORD_ALL);
		settle();
	endtask

	task automatic test_register_writes();
		// spare indexes must leave both registers alone
		write_reg(REG_SPARE_2, '1);
		write_reg(REG_SPARE_3, '1);
		send_item(mhsba_pkg::IDX_W'(20), 32'h8000_0000);
		settle();
		write_reg(mhsba_pkg::REG_BLOCKS_LOG2, '1);
		write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2, '1);
		send_item(26'h1FF_FFFF, WORD_ALL);
		send_item(26'h200_0000, WORD_ALL);
		send_item(26'h3FF_FFFF, WORD_ALL);
		send_item(26'h3FF_FFFF, '0);
		send_item(mhsba_pkg::IDX_W'(5), '0);
		settle();
		write_reg(mhsba_pkg::REG_BLOCKS_LOG2, '0);
		write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2, '0);
		send_item(mhsba_pkg::IDX_W'(31), 32'h1234_5678);
		send_item(mhsba_pkg::IDX_W'(32), 32'h1234_5678);
		settle();
		write_reg(mhsba_pkg::REG_BLOCKS_LOG2, mhsba_pkg::CFG_DATA_W'(BLOCKS_LOG2_CAP));
		write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2, mhsba_pkg::CFG_DATA_W'(mhsba_pkg::LL_MAX));
		send_item(26'h100_3039, 32'hC000_0000);
		send_item('1, 32'h0000_0001);
		settle();
	endtask

	task automatic test_random_settings();
		int unsigned phase;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					write_reg(mhsba_pkg::REG_BLOCKS_LOG2,
						mhsba_pkg::CFG_DATA_W'(mhsba_pkg::BL_MIN));
					write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2,
						mhsba_pkg::CFG_DATA_W'(mhsba_pkg::LL_MIN));
				end
				1: begin
					write_reg(mhsba_pkg::REG_BLOCKS_LOG2,
						mhsba_pkg::CFG_DATA_W'(BLOCKS_LOG2_CAP));
					write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2,
						mhsba_pkg::CFG_DATA_W'(mhsba_pkg::LL_MAX));
				end
				default: begin
					write_reg(mhsba_pkg::REG_BLOCKS_LOG2,
						mhsba_pkg::CFG_DATA_W'($urandom_range(0, 31)));
					write_reg(mhsba_pkg::REG_BLOCK_LEN_LOG2,
						mhsba_pkg::CFG_DATA_W'($urandom_range(0, 31)));
					if ($urandom_range(0, 1) == 0)
						write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
							mhsba_pkg::CFG_DATA_W'($urandom));
				end
			endcase
			// hold off gaps on some phases and on the tail of the run
			gaps_on = (phase < RANDOM_PHASES - 2) && (phase % 4 != 3);
			repeat (BEATS_PER_PHASE) send_item(random_index(), random_word());
		end
		settle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_register_writes();
		test_random_settings();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
sv/mhsba_pkg.sv
sv/mhsba_slide.sv
sv/mhsba_cube.sv
sv/memory_hard_source_block_address_unit.sv
sv/mhsba_checker.sv
tb/tb_top.sv
